FILE: rtl/core/usr_pkg.sv
// Types, codes and helpers shared by the USB standard request handler.
`timescale 1ns / 1ps

package usr_pkg;

    // Event kinds
    localparam logic [1:0] KIND_SETUP     = 2'd0;
    localparam logic [1:0] KIND_DATA      = 2'd1;
    localparam logic [1:0] KIND_STATUS    = 2'd2;
    localparam logic [1:0] KIND_BUS_RESET = 2'd3;

    // bmRequestType type field
    localparam logic [1:0] RT_TYPE_STANDARD = 2'd0;
    localparam logic [1:0] RT_TYPE_CLASS    = 2'd1;

    // Full bmRequestType values checked by the standard requests
    localparam logic [7:0] RT_OUT_DEVICE    = 8'h00;
    localparam logic [7:0] RT_OUT_INTERFACE = 8'h01;
    localparam logic [7:0] RT_OUT_ENDPOINT  = 8'h02;
    localparam logic [7:0] RT_IN_DEVICE     = 8'h80;
    localparam logic [7:0] RT_IN_INTERFACE  = 8'h81;
    localparam logic [7:0] RT_IN_ENDPOINT   = 8'h82;

    // bRequest codes
    localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] RQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

    // Descriptor types and language ids
    localparam logic [7:0]  DT_DEVICE = 8'd1;
    localparam logic [7:0]  DT_CONFIG = 8'd2;
    localparam logic [7:0]  DT_STRING = 8'd3;
    localparam logic [15:0] LANG_EN_US = 16'h0409;
    localparam logic [15:0] LANG_JA    = 16'h0411;
    localparam logic [15:0] MAX_ADDRESS = 16'd127;

    // Verdicts
    localparam logic [2:0] VERDICT_ACCEPT  = 3'd0;
    localparam logic [2:0] VERDICT_STALL   = 3'd1;
    localparam logic [2:0] VERDICT_REPLY   = 3'd2;
    localparam logic [2:0] VERDICT_FETCH   = 3'd3;
    localparam logic [2:0] VERDICT_FORWARD = 3'd4;

    // Endpoint marks
    localparam logic [1:0] MARK_DISABLED = 2'd0;
    localparam logic [1:0] MARK_ENABLED  = 2'd1;
    localparam logic [1:0] MARK_HALTED   = 2'd2;

    // Reported device state codes
    localparam logic [1:0] DEV_STATE_POWERED    = 2'd0;
    localparam logic [1:0] DEV_STATE_DEFAULT    = 2'd1;
    localparam logic [1:0] DEV_STATE_ADDRESS    = 2'd2;
    localparam logic [1:0] DEV_STATE_CONFIGURED = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_CONFIG_VALUE       = 3'd0;
    localparam logic [2:0] CFG_NOTIFY_EP          = 3'd1;
    localparam logic [2:0] CFG_RX_EP              = 3'd2;
    localparam logic [2:0] CFG_TX_EP              = 3'd3;
    localparam logic [2:0] CFG_STRING_INDEX_LIMIT = 3'd4;
    localparam logic [2:0] CFG_INTERFACE_COUNT    = 3'd5;
    localparam logic [2:0] CFG_COMM_INTERFACE     = 3'd6;
    localparam logic [2:0] CFG_DATA_INTERFACE     = 3'd7;

    typedef enum logic [3:0] {
        MODE_POWERED    = 4'b0001,
        MODE_DEFAULT    = 4'b0010,
        MODE_ADDRESS    = 4'b0100,
        MODE_CONFIGURED = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] reply_data;
        logic [15:0] reply_length;
        logic [1:0]  device_state_now;
        logic        address_write;
        logic [6:0]  new_address;
        logic [5:0]  endpoint_marks;
        logic [2:0]  toggle_reset_mask;
    } t_req_result;

    typedef struct packed {
        logic [7:0] config_value;
        logic [7:0] notify_ep_address;
        logic [7:0] rx_ep_address;
        logic [7:0] tx_ep_address;
        logic [7:0] string_index_limit;
        logic [4:0] interface_count;
        logic [3:0] comm_interface;
        logic [3:0] data_interface;
    } t_cfg;

    typedef struct packed {
        t_mode           mode;
        logic [2:0][1:0] marks;   // notify, rx, tx from index 0
    } t_dev_state;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_POWERED:    c = DEV_STATE_POWERED;
            MODE_DEFAULT:    c = DEV_STATE_DEFAULT;
            MODE_ADDRESS:    c = DEV_STATE_ADDRESS;
            MODE_CONFIGURED: c = DEV_STATE_CONFIGURED;
            default:         c = DEV_STATE_POWERED;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/usr_decide.sv
// Request check, reply and next device state for one control event.
`timescale 1ns / 1ps

module usr_decide (
    input  usr_pkg::t_req_item   i_item,
    input  usr_pkg::t_cfg        i_cfg,
    input  usr_pkg::t_dev_state  i_state,
    output usr_pkg::t_req_result o_result,
    output usr_pkg::t_dev_state  o_state
);
    import usr_pkg::*;

    logic [7:0]  rt;
    logic [15:0] v;
    logic [15:0] ix;
    logic [15:0] ln;
    logic [7:0]  dt;
    logic [7:0]  di;
    logic [1:0]  rtype;
    logic        is_in;
    logic        dflt;
    logic        addr_m;
    logic        conf_m;
    logic        ix_zero;
    logic [2:0]  hit;
    logic        slot_ok;
    logic        ep_bad;
    logic        ifc_bad;
    logic        st_bad;
    logic        fails;

    assign rt      = i_item.request_type;
    assign v       = i_item.setup_value;
    assign ix      = i_item.setup_index;
    assign ln      = i_item.setup_length;
    assign dt      = v[15:8];
    assign di      = v[7:0];
    assign rtype   = rt[6:5];
    assign is_in   = rt[7];
    assign dflt    = (i_state.mode == MODE_DEFAULT);
    assign addr_m  = (i_state.mode == MODE_ADDRESS);
    assign conf_m  = (i_state.mode == MODE_CONFIGURED);
    assign ix_zero = (ix == 16'd0);

    // First match wins: notify, then rx, then tx
    assign hit[0] = !ix_zero && (ix == {8'h00, i_cfg.notify_ep_address});
    assign hit[1] = !ix_zero && !hit[0] && (ix == {8'h00, i_cfg.rx_ep_address});
    assign hit[2] = !ix_zero && !hit[0] && !hit[1] && (ix == {8'h00, i_cfg.tx_ep_address});
    assign slot_ok = |hit;
    assign ep_bad  = !ix_zero && (!conf_m || !slot_ok);
    assign ifc_bad = (ix >= {11'd0, i_cfg.interface_count});

    always_comb begin
        st_bad = 1'b1;
        unique case (rt)
            RT_IN_DEVICE:    st_bad = !ix_zero;
            RT_IN_INTERFACE: st_bad = ifc_bad || !conf_m;
            RT_IN_ENDPOINT:  st_bad = ep_bad;
            default:         st_bad = 1'b1;
        endcase
    end

    always_comb begin
        fails = 1'b1;
        unique case (i_item.request_code) inside
            RQ_GET_DESCRIPTOR: begin
                if (rt != RT_IN_DEVICE) begin
                    fails = 1'b1;
                end else if (dt == DT_DEVICE || dt == DT_CONFIG) begin
                    fails = (di != 8'd0) || !ix_zero;
                end else if (dt == DT_STRING) begin
                    fails = ((di == 8'd0) && !ix_zero)
                         || ((di != 8'd0) && (ix != LANG_EN_US) && (ix != LANG_JA))
                         || (di > i_cfg.string_index_limit);
                end else begin
                    fails = 1'b1;
                end
            end
            RQ_GET_CONFIGURATION: begin
                fails = (rt != RT_IN_DEVICE) || (v != 16'd0) || !ix_zero
                     || (ln != 16'd1) || dflt;
            end
            RQ_GET_INTERFACE: begin
                fails = (rt != RT_IN_INTERFACE) || ifc_bad || addr_m || (v != 16'd0)
                     || (ln != 16'd1) || dflt;
            end
            RQ_GET_STATUS: begin
                fails = st_bad || (v != 16'd0) || (ln != 16'd2) || dflt;
            end
            RQ_SET_ADDRESS: begin
                fails = (rt != RT_OUT_DEVICE) || (v > MAX_ADDRESS) || !ix_zero
                     || (ln != 16'd0) || conf_m;
            end
            RQ_SET_CONFIGURATION: begin
                fails = (rt != RT_OUT_DEVICE)
                     || ((v != 16'd0) && (v != {8'h00, i_cfg.config_value}))
                     || !ix_zero || (ln != 16'd0) || dflt;
            end
            RQ_SET_INTERFACE: begin
                fails = (rt != RT_OUT_INTERFACE) || (v != 16'd0) || ifc_bad || addr_m
                     || (ln != 16'd0) || dflt;
            end
            RQ_SET_FEATURE, RQ_CLEAR_FEATURE: begin
                fails = (rt != RT_OUT_ENDPOINT) || (v != 16'd0) || ep_bad
                     || (ln != 16'd0) || dflt;
            end
            default: fails = 1'b1;
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.kind == KIND_BUS_RESET) begin
            o_state.mode  = MODE_DEFAULT;
            o_state.marks = {3{MARK_DISABLED}};
        end else if (i_state.mode == MODE_POWERED) begin
            o_result.verdict = VERDICT_STALL;
        end else if (rtype == RT_TYPE_CLASS) begin
            if (!conf_m) begin
                o_result.verdict = VERDICT_STALL;
            end else if (i_item.kind == KIND_STATUS && is_in) begin
                o_result.verdict = VERDICT_ACCEPT;
            end else begin
                o_result.verdict = VERDICT_FORWARD;
            end
        end else if (rtype != RT_TYPE_STANDARD) begin
            o_result.verdict = VERDICT_STALL;
        end else if (i_item.kind == KIND_SETUP) begin
            if (fails) begin
                o_result.verdict = VERDICT_STALL;
            end else if (is_in) begin
                o_result.verdict = VERDICT_REPLY;
                if (i_item.request_code == RQ_GET_DESCRIPTOR) begin
                    o_result.verdict      = VERDICT_FETCH;
                    o_result.reply_length = ln;
                end else if (i_item.request_code == RQ_GET_CONFIGURATION) begin
                    o_result.reply_data   = addr_m ? 16'd0 : {8'h00, i_cfg.config_value};
                    o_result.reply_length = 16'd1;
                end else if (i_item.request_code == RQ_GET_INTERFACE) begin
                    o_result.reply_length = 16'd1;
                end else begin
                    o_result.reply_length = 16'd2;
                    if (rt == RT_IN_ENDPOINT) begin
                        for (int s = 0; s < 3; s++) begin
                            if (hit[s] && i_state.marks[s] == MARK_HALTED) begin
                                o_result.reply_data = 16'd1;
                            end
                        end
                    end
                end
            end
        end else if (i_item.kind == KIND_STATUS && !is_in) begin
            if (fails) begin
                o_result.verdict = VERDICT_STALL;
            end else if (i_item.request_code == RQ_SET_ADDRESS) begin
                if (dflt && v != 16'd0) begin
                    o_state.mode = MODE_ADDRESS;
                end else if (addr_m && v == 16'd0) begin
                    o_state.mode = MODE_DEFAULT;
                end
                o_result.address_write = 1'b1;
                o_result.new_address   = v[6:0];
            end else if (i_item.request_code == RQ_SET_CONFIGURATION) begin
                if (addr_m && v != 16'd0) begin
                    o_state.mode  = MODE_CONFIGURED;
                    o_state.marks = {3{MARK_ENABLED}};
                end else if (conf_m && v == 16'd0) begin
                    o_state.mode  = MODE_ADDRESS;
                    o_state.marks = {3{MARK_DISABLED}};
                end else begin
                    for (int s = 0; s < 3; s++) begin
                        if (i_state.marks[s] == MARK_HALTED) begin
                            o_state.marks[s] = MARK_ENABLED;
                        end
                    end
                end
            end else if (i_item.request_code == RQ_SET_INTERFACE) begin
                if (ix == {12'd0, i_cfg.comm_interface}) begin
                    if (i_state.marks[0] == MARK_HALTED) begin
                        o_state.marks[0] = MARK_ENABLED;
                    end
                end else if (ix == {12'd0, i_cfg.data_interface}) begin
                    for (int s = 1; s < 3; s++) begin
                        if (i_state.marks[s] == MARK_HALTED) begin
                            o_state.marks[s] = MARK_ENABLED;
                        end
                    end
                end
            end else if (i_item.request_code == RQ_SET_FEATURE) begin
                for (int s = 0; s < 3; s++) begin
                    if (hit[s]) begin
                        o_state.marks[s] = MARK_HALTED;
                    end
                end
            end else if (i_item.request_code == RQ_CLEAR_FEATURE) begin
                for (int s = 0; s < 3; s++) begin
                    if (hit[s] && i_state.marks[s] == MARK_HALTED) begin
                        o_state.marks[s]              = MARK_ENABLED;
                        o_result.toggle_reset_mask[s] = 1'b1;
                    end
                end
            end
        end
        o_result.device_state_now = mode_code(o_state.mode);
        o_result.endpoint_marks   = o_state.marks;
    end

endmodule

FILE: rtl/core/usb_standard_request_handler_top.sv
// Top level of the USB standard request handler: registers, handshake and state.
`timescale 1ns / 1ps

// Takes one control transfer event per item (setup, data or status stage with the
// eight setup bytes, or a bus reset) and returns exactly one result item for it:
// a verdict, any reply bytes for get configuration, get interface and get status,
// the device state after the event, a set address strobe, the three endpoint marks
// and the data toggle reset mask. One item is accepted every cycle unless the consumer
// stalls; an accepted item is loaded into the input register and its result goes
// into the result register once the output slot is free, with the device state and
// endpoint marks updated in the same cycle the result is registered, so the next item
// already sees them. The output register holds a result while the consumer stalls
// and the input register keeps accepting until it also fills. Configuration
// registers are written through a plain write port and should only change while no
// item is in flight.
module usb_standard_request_handler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // Event channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  usr_pkg::t_req_item   i_in,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output usr_pkg::t_req_result o_out
);
    import usr_pkg::*;

    t_cfg        r_cfg;
    t_cfg        n_cfg;
    t_dev_state  r_state;
    t_dev_state  n_state;
    logic        r_in_valid;
    t_req_item   r_in;
    logic        r_out_valid;
    t_req_result r_out;
    t_req_result n_out;
    logic        advance;

    // Move the held item into the result register when that slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    usr_decide u_decide (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    // Register writes: truncate data to each register's width
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CONFIG_VALUE:       n_cfg.config_value       = i_cfg_data;
                CFG_NOTIFY_EP:          n_cfg.notify_ep_address  = i_cfg_data;
                CFG_RX_EP:              n_cfg.rx_ep_address      = i_cfg_data;
                CFG_TX_EP:              n_cfg.tx_ep_address      = i_cfg_data;
                CFG_STRING_INDEX_LIMIT: n_cfg.string_index_limit = i_cfg_data;
                CFG_INTERFACE_COUNT:    n_cfg.interface_count    = i_cfg_data[4:0];
                CFG_COMM_INTERFACE:     n_cfg.comm_interface     = i_cfg_data[3:0];
                CFG_DATA_INTERFACE:     n_cfg.data_interface     = i_cfg_data[3:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.config_value       <= 8'd1;
            r_cfg.notify_ep_address  <= 8'h81;
            r_cfg.rx_ep_address      <= 8'h02;
            r_cfg.tx_ep_address      <= 8'h82;
            r_cfg.string_index_limit <= 8'd3;
            r_cfg.interface_count    <= 5'd2;
            r_cfg.comm_interface     <= 4'd0;
            r_cfg.data_interface     <= 4'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Control state: valid flags, device mode and endpoint marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.mode  <= MODE_POWERED;
            r_state.marks <= {3{MARK_DISABLED}};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A set address strobe only comes with an accepted status stage
    a_addr_write_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.address_write |-> o_out.verdict == VERDICT_ACCEPT)
        else $error("address write without accept verdict");

    // Endpoints carry marks only in the configured state
    a_marks_need_config: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.device_state_now != DEV_STATE_CONFIGURED
        |-> o_out.endpoint_marks == 6'd0)
        else $error("endpoint marked outside configured state");

    // A toggle reset comes from an accepted clear halt only
    a_toggle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.toggle_reset_mask != 3'd0
        |-> o_out.verdict == VERDICT_ACCEPT && $onehot(o_out.toggle_reset_mask))
        else $error("toggle reset without single accepted clear halt");

    // A held input item is never dropped: if it cannot advance, input stays blocked
    a_hold_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |-> !o_in_ready)
        else $error("input accepted over a held item");

endmodule
